[sv/largest_aligned_gap_finder_defines.svh]
// Assertion macros shared by the checker of the largest aligned gap finder.
`ifndef LARGEST_ALIGNED_GAP_FINDER_DEFINES_SVH
`define LARGEST_ALIGNED_GAP_FINDER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define LAGF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define LAGF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define LAGF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/lagf_pkg.sv]
`timescale 1ns / 1ps

package lagf_pkg;

   // Sector numbers and the wider forms used for the cursor and aligned start.
   localparam int SECT_W  = 48;
   localparam int CUR_W   = SECT_W + 1;
   localparam int AL_W    = SECT_W + 2;
   localparam int SHIFT_W = 5;
   localparam int MASK_W  = 31;

   // Register port.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_LOW_SECTOR  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_SECTOR = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ALIGN_SHIFT = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_MIN_GAP     = 2'd3;

   // Reset values: 34 is the first sector after a standard table, an
   // alignment of 2^11 = 2048 sectors, and a minimum gap of 40960 sectors.
   localparam logic [SECT_W-1:0]  RST_LOW_SECTOR  = 48'd34;
   localparam logic [SECT_W-1:0]  RST_HIGH_SECTOR = 48'd0;
   localparam logic [SHIFT_W-1:0] RST_ALIGN_SHIFT = 5'd11;
   localparam logic [SECT_W-1:0]  RST_MIN_GAP     = 48'd40960;

   typedef struct packed {
      logic init;
      logic align;
      logic measure;
      logic use_ext;
   } lagf_gap_ctl_type;

   typedef struct packed {
      logic clear;
      logic commit;
   } lagf_sel_ctl_type;

endpackage

[sv/lagf_ram.sv]
`timescale 1ns / 1ps

module lagf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lagf_select.sv]
`timescale 1ns / 1ps

// Finds, over one sweep of the table, the smallest (start, index) key that
// lies above the key taken on the previous pass.
module lagf_select #(
   parameter int IDX_W = 7
) (
   input  logic                         clock,
   input  lagf_pkg::lagf_sel_ctl_type   ctl,
   input  logic                         rd_vld,
   input  logic [IDX_W-1:0]             rd_idx,
   input  logic [lagf_pkg::SECT_W-1:0]  rd_start,
   input  logic [lagf_pkg::SECT_W-1:0]  rd_end,
   output logic [lagf_pkg::SECT_W-1:0]  cand_start,
   output logic [lagf_pkg::SECT_W-1:0]  cand_end
);

   import lagf_pkg::*;

   logic                last_vld_ff, last_vld_in;
   logic [SECT_W-1:0]   last_s_ff, last_s_in;
   logic [IDX_W-1:0]    last_i_ff, last_i_in;
   logic                cand_vld_ff, cand_vld_in;
   logic [SECT_W-1:0]   cand_s_ff, cand_s_in;
   logic [SECT_W-1:0]   cand_e_ff, cand_e_in;
   logic [IDX_W-1:0]    cand_i_ff, cand_i_in;
   logic                above_last;
   logic                below_cand;

   assign above_last = !last_vld_ff || ({rd_start, rd_idx} > {last_s_ff, last_i_ff});
   assign below_cand = !cand_vld_ff || ({rd_start, rd_idx} < {cand_s_ff, cand_i_ff});

   always_comb begin
      last_vld_in = last_vld_ff;
      last_s_in   = last_s_ff;
      last_i_in   = last_i_ff;
      cand_vld_in = cand_vld_ff;
      cand_s_in   = cand_s_ff;
      cand_e_in   = cand_e_ff;
      cand_i_in   = cand_i_ff;
      priority if (ctl.clear) begin
         last_vld_in = 1'b0;
         cand_vld_in = 1'b0;
      end else if (ctl.commit) begin
         last_vld_in = 1'b1;
         last_s_in   = cand_s_ff;
         last_i_in   = cand_i_ff;
         cand_vld_in = 1'b0;
      end else if (rd_vld && above_last && below_cand) begin
         cand_vld_in = 1'b1;
         cand_s_in   = rd_start;
         cand_e_in   = rd_end;
         cand_i_in   = rd_idx;
      end else begin
         // Nothing to take this cycle, so the candidate holds.
      end
   end

   always_ff @(posedge clock) begin
      last_vld_ff <= last_vld_in;
      last_s_ff   <= last_s_in;
      last_i_ff   <= last_i_in;
      cand_vld_ff <= cand_vld_in;
      cand_s_ff   <= cand_s_in;
      cand_e_ff   <= cand_e_in;
      cand_i_ff   <= cand_i_in;
   end

   assign cand_start = cand_s_ff;
   assign cand_end   = cand_e_ff;

endmodule

[sv/lagf_gap.sv]
`timescale 1ns / 1ps

// Cursor and best-gap tracker. Each step is an align followed by a
// measure.
module lagf_gap (
   input  logic                          clock,
   input  lagf_pkg::lagf_gap_ctl_type    ctl,
   input  logic [lagf_pkg::SECT_W-1:0]   low_sector,
   input  logic [lagf_pkg::SHIFT_W-1:0]  align_shift,
   input  logic [lagf_pkg::CUR_W-1:0]    gap_end,
   input  logic [lagf_pkg::SECT_W-1:0]   ext_last,
   output logic [lagf_pkg::CUR_W-1:0]    best,
   output logic [lagf_pkg::SECT_W-1:0]   best_pos
);

   import lagf_pkg::*;

   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [AL_W-1:0]   start_ff, start_in;
   logic [CUR_W-1:0]  best_ff, best_in;
   logic [SECT_W-1:0] best_pos_ff, best_pos_in;
   logic [AL_W-1:0]   end_ext;
   logic [AL_W-1:0]   diff;
   logic [CUR_W-1:0]  ext_next;
   logic [31:0]       pow2;

   assign pow2     = 32'd1 << align_shift;
   assign end_ext  = AL_W'(gap_end);
   assign diff     = end_ext - start_ff;
   assign ext_next = CUR_W'(ext_last) + CUR_W'(1);

   always_comb begin
      mask_in     = mask_ff;
      cursor_in   = cursor_ff;
      start_in    = start_ff;
      best_in     = best_ff;
      best_pos_in = best_pos_ff;
      if (ctl.init) begin
         mask_in     = MASK_W'(pow2 - 32'd1);
         cursor_in   = CUR_W'(low_sector);
         best_in     = '0;
         best_pos_in = '0;
      end
      if (ctl.align) begin
         start_in = (AL_W'(cursor_ff) + AL_W'(mask_ff)) & ~AL_W'(mask_ff);
      end
      if (ctl.measure) begin
         // A positive gap is at most 2^48 long and starts below 2^48.
         if (end_ext > start_ff && diff[CUR_W-1:0] > best_ff) begin
            best_in     = diff[CUR_W-1:0];
            best_pos_in = start_ff[SECT_W-1:0];
         end
         if (ctl.use_ext && ext_next > cursor_ff) begin
            cursor_in = ext_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      cursor_ff   <= cursor_in;
      start_ff    <= start_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
   end

   assign best     = best_ff;
   assign best_pos = best_pos_ff;

endmodule

[sv/largest_aligned_gap_finder.sv]
// Largest aligned gap finder. Partition extents arrive one per request
// transaction as (first, last) sector pairs and are stored in two on-chip
// RAMs of MAX_EXTENTS entries; a request without an entry only triggers, and
// extents beyond MAX_EXTENTS are dropped. Each request that is not marked
// final leaves the block idle. After a final request the block stalls the request
// channel and searches: it visits the extents in order of first sector by
// repeated selection passes over the RAM, one entry read per cycle, and
// before each extent, and once more before the last usable sector plus one,
// rounds a cursor up to 2^align_shift and keeps the strictly largest gap.
// With n extents the search time is set by the RAM read ports, which each
// of the n passes sweeps. The result transaction reports the gap, or
// found = 0 with zero start and length when the best gap is empty or below
// min_gap_sectors; it is held in an output register, so new requests are
// taken while it waits.
`timescale 1ns / 1ps

module largest_aligned_gap_finder #(
   parameter int MAX_EXTENTS = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_has_entry,
   input  logic [lagf_pkg::SECT_W-1:0]     req_extent_first,
   input  logic [lagf_pkg::SECT_W-1:0]     req_extent_last,
   input  logic                            req_final_item,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [lagf_pkg::SECT_W-1:0]     rsp_gap_start,
   output logic [lagf_pkg::SECT_W-1:0]     rsp_gap_length,
   // Register port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lagf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lagf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lagf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   import lagf_pkg::*;

   localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
   localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_STEP_A = 3'd2;
   localparam logic [2:0] ST_STEP_B = 3'd3;
   localparam logic [2:0] ST_FIN_A  = 3'd4;
   localparam logic [2:0] ST_FIN_B  = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   // Configuration registers.
   logic [SECT_W-1:0]  low_sector_ff, low_sector_in;
   logic [SECT_W-1:0]  high_sector_ff, high_sector_in;
   logic [SHIFT_W-1:0] align_shift_ff, align_shift_in;
   logic [SECT_W-1:0]  min_gap_ff, min_gap_in;
   logic               csr_wr;
   logic [REG_IDX_W-1:0] reg_idx;

   // Control.
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_last_ff, rd_last_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             req_acc;
   logic             wr_en;
   logic             issuing;
   logic             out_load;

   // Response registers.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SECT_W-1:0] rsp_start_ff, rsp_start_in;
   logic [SECT_W-1:0] rsp_len_ff, rsp_len_in;

   // Datapath connections.
   logic [SECT_W-1:0] rd_start;
   logic [SECT_W-1:0] rd_end;
   logic [SECT_W-1:0] cand_start;
   logic [SECT_W-1:0] cand_end;
   logic [CUR_W-1:0]  gap_end;
   logic [CUR_W-1:0]  best;
   logic [SECT_W-1:0] best_pos;
   logic              is_found;
   lagf_gap_ctl_type  gap_ctl;
   lagf_sel_ctl_type  sel_ctl;

   //--------------------------------------------------------------------
   // Register port. Registers sit on 8-byte boundaries; writes complete in
   // the access phase and reads return the stored value.
   //--------------------------------------------------------------------
   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      low_sector_in  = low_sector_ff;
      high_sector_in = high_sector_ff;
      align_shift_in = align_shift_ff;
      min_gap_in     = min_gap_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_LOW_SECTOR:  low_sector_in  = pwdata[SECT_W-1:0];
            REG_HIGH_SECTOR: high_sector_in = pwdata[SECT_W-1:0];
            REG_ALIGN_SHIFT: align_shift_in = pwdata[SHIFT_W-1:0];
            REG_MIN_GAP:     min_gap_in     = pwdata[SECT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LOW_SECTOR:  prdata = CSR_DATA_W'(low_sector_ff);
         REG_HIGH_SECTOR: prdata = CSR_DATA_W'(high_sector_ff);
         REG_ALIGN_SHIFT: prdata = CSR_DATA_W'(align_shift_ff);
         REG_MIN_GAP:     prdata = CSR_DATA_W'(min_gap_ff);
      endcase
   end

   //--------------------------------------------------------------------
   // Extent storage. A request is taken only in the idle state, and its
   // extent is written at the current fill count while room remains.
   //--------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign wr_en     = req_acc && req_has_entry && (count_ff < CNT_W'(MAX_EXTENTS));

   // One selection pass reads every stored entry once, in address order.
   assign issuing = (state_ff == ST_SCAN) && (scan_ff < count_ff);

   lagf_ram #(
      .WIDTH (SECT_W),
      .DEPTH (MAX_EXTENTS)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_extent_first),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_start)
   );

   lagf_ram #(
      .WIDTH (SECT_W),
      .DEPTH (MAX_EXTENTS)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_extent_last),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_end)
   );

   //--------------------------------------------------------------------
   // Sequencer. Each pass is a sweep of the table, a drain step for the
   // registered read, then an align and a measure step on the selected
   // extent. The closing step measures up to the last usable sector plus one.
   //--------------------------------------------------------------------
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      pass_in    = pass_ff;
      rd_vld_in  = issuing;
      rd_last_in = issuing && (scan_ff == count_ff - CNT_W'(1));
      sel_ctl    = '0;
      gap_ctl    = '0;

      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (issuing) begin
         scan_in = scan_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_final_item) begin
               sel_ctl.clear = 1'b1;
               gap_ctl.init  = 1'b1;
               scan_in       = '0;
               pass_in       = '0;
               state_in      = (count_in == '0) ? ST_FIN_A : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_last_ff) begin
               state_in = ST_STEP_A;
            end
         end
         ST_STEP_A: begin
            gap_ctl.align = 1'b1;
            state_in      = ST_STEP_B;
         end
         ST_STEP_B: begin
            gap_ctl.measure = 1'b1;
            gap_ctl.use_ext = 1'b1;
            sel_ctl.commit  = 1'b1;
            scan_in         = '0;
            pass_in         = pass_ff + CNT_W'(1);
            state_in        = (pass_in == count_ff) ? ST_FIN_A : ST_SCAN;
         end
         ST_FIN_A: begin
            gap_ctl.align = 1'b1;
            state_in      = ST_FIN_B;
         end
         ST_FIN_B: begin
            gap_ctl.measure = 1'b1;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_ff[IDX_W-1:0];
   end

   lagf_select #(
      .IDX_W (IDX_W)
   ) u_select (
      .clock      (clock),
      .ctl        (sel_ctl),
      .rd_vld     (rd_vld_ff),
      .rd_idx     (rd_idx_ff),
      .rd_start   (rd_start),
      .rd_end     (rd_end),
      .cand_start (cand_start),
      .cand_end   (cand_end)
   );

   // The closing step's boundary is the last usable sector plus one, which
   // may reach 2^48.
   assign gap_end = (state_ff == ST_FIN_B) ? (CUR_W'(high_sector_ff) + CUR_W'(1))
                                           : CUR_W'(cand_start);

   lagf_gap u_gap (
      .clock       (clock),
      .ctl         (gap_ctl),
      .low_sector  (low_sector_ff),
      .align_shift (align_shift_ff),
      .gap_end     (gap_end),
      .ext_last    (cand_end),
      .best        (best),
      .best_pos    (best_pos)
   );

   //--------------------------------------------------------------------
   // Response. An empty best gap never counts as found, even with a zero
   // minimum; a gap of exactly 2^48 sectors saturates its length.
   //--------------------------------------------------------------------
   assign is_found = (best != '0) && (best >= CUR_W'(min_gap_ff));

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = is_found;
         rsp_start_in = is_found ? best_pos : '0;
         if (!is_found) begin
            rsp_len_in = '0;
         end else if (best[CUR_W-1]) begin
            rsp_len_in = '1;
         end else begin
            rsp_len_in = best[SECT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_sector_ff  <= RST_LOW_SECTOR;
         high_sector_ff <= RST_HIGH_SECTOR;
         align_shift_ff <= RST_ALIGN_SHIFT;
         min_gap_ff     <= RST_MIN_GAP;
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         scan_ff        <= '0;
         pass_ff        <= '0;
         rd_vld_ff      <= 1'b0;
         rd_last_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         low_sector_ff  <= low_sector_in;
         high_sector_ff <= high_sector_in;
         align_shift_ff <= align_shift_in;
         min_gap_ff     <= min_gap_in;
         state_ff       <= state_in;
         count_ff       <= count_in;
         scan_ff        <= scan_in;
         pass_ff        <= pass_in;
         rd_vld_ff      <= rd_vld_in;
         rd_last_ff     <= rd_last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_gap_start  = rsp_start_ff;
   assign rsp_gap_length = rsp_len_ff;

endmodule

[sv/lagf_checker.sv]
`timescale 1ns / 1ps
`include "largest_aligned_gap_finder_defines.svh"

module lagf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_final_item,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_found,
   input logic [lagf_pkg::SECT_W-1:0] rsp_gap_start,
   input logic [lagf_pkg::SECT_W-1:0] rsp_gap_length
);

   import lagf_pkg::*;

   // Reset leaves no response pending.
   `LAGF_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid)

   // A final request starts a search, during which no request is taken.
   `LAGF_ASSERT_NEXT(a_final_busy, clock, reset, req_valid && !req_stall && req_final_item, req_stall)

   // A miss reports a zero start and length.
   `LAGF_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_gap_start == '0 && rsp_gap_length == '0)

   // A hit always carries a nonempty gap.
   `LAGF_ASSERT_IMPL(a_hit_nonempty, clock, reset, rsp_valid && rsp_found, rsp_gap_length != '0)

   // A stalled response holds its payload.
   `LAGF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_gap_start) && $stable(rsp_gap_length))

endmodule

bind largest_aligned_gap_finder lagf_checker u_lagf_checker (.*);

[tb/tb_largest_aligned_gap_finder.sv]
`timescale 1ns / 1ps

module tb_largest_aligned_gap_finder;
   import lagf_pkg::*;

   // The block is built with its default table depth, and the prediction of
   // the table follows the same depth.
   localparam int TABLE_DEPTH = 128;
   localparam longint unsigned SECTOR_MASK = 64'h0000_FFFF_FFFF_FFFF;

   // During the search after a full table no request is accepted; a result
   // is accepted only if an earlier one still waits. The watchdog limit lies
   // well above that search time, so only a real hang trips it.
   localparam int WATCHDOG_LIMIT = 200000;

   // A request that is not final leaves the block idle, so a short wait after the
   // last result is enough before the registers are touched.
   localparam int SETTLE_CYCLES = 16;

   // Counted request transactions in the random part of the run.
   localparam int RANDOM_ITEMS = 1500;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // One expected result transaction.
   typedef struct {
      logic              found;
      logic [SECT_W-1:0] gap_start;
      logic [SECT_W-1:0] gap_length;
   } gap_report_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_has_entry;
   logic [SECT_W-1:0]     req_extent_first;
   logic [SECT_W-1:0]     req_extent_last;
   logic                  req_final_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_found;
   logic [SECT_W-1:0]     rsp_gap_start;
   logic [SECT_W-1:0]     rsp_gap_length;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Our own copy of the register file, tracked on every write.
   logic [SECT_W-1:0]  cfg_low_sector  = RST_LOW_SECTOR;
   logic [SECT_W-1:0]  cfg_high_sector = RST_HIGH_SECTOR;
   logic [SHIFT_W-1:0] cfg_align_shift = RST_ALIGN_SHIFT;
   logic [SECT_W-1:0]  cfg_min_gap     = RST_MIN_GAP;

   // Our own copy of the extent table that the block is collecting.
   longint unsigned table_first [TABLE_DEPTH];
   longint unsigned table_last  [TABLE_DEPTH];
   int              table_count = 0;

   // Gap reports that the block still owes us, oldest first.
   gap_report_type pending_gaps[$];

   int error_count = 0;
   int total_items = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   largest_aligned_gap_finder #(
      .MAX_EXTENTS(TABLE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_has_entry    (req_has_entry),
      .req_extent_first (req_extent_first),
      .req_extent_last  (req_extent_last),
      .req_final_item   (req_final_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_gap_start    (rsp_gap_start),
      .rsp_gap_length   (rsp_gap_length),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every mismatch goes through here. Printing is capped so that a badly
   // broken design cannot flood the log, but every mismatch is counted.
   task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
      error_count++;
      if (error_count <= 50) begin
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
      end
   endtask

   function automatic longint unsigned rand48();
      return {$urandom, $urandom} & SECTOR_MASK;
   endfunction

   function automatic longint unsigned rand_below(longint unsigned limit);
      if (limit == 0) begin
         return 0;
      end
      return {$urandom, $urandom} % limit;
   endfunction

   // ------------------------------------------------------------------
   // Prediction of the block.
   // ------------------------------------------------------------------

   // Sorts the held extents by first sector, then walks the cursor across
   // them. Each gap starts at the cursor rounded up to the alignment and
   // ends at the next extent's first sector, or at the last usable sector
   // plus one for the closing gap. Only a strictly larger gap replaces the
   // best one, so the earlier gap wins a tie. Arithmetic is 64 bits wide so
   // that the cursor, the rounding and the closing gap never wrap.
   function automatic gap_report_type predict_best_gap();
      longint unsigned sorted_first [TABLE_DEPTH];
      longint unsigned sorted_last  [TABLE_DEPTH];
      longint unsigned key_first;
      longint unsigned key_last;
      longint unsigned align_mask;
      longint unsigned cursor;
      longint unsigned gap_end;
      longint unsigned aligned;
      longint unsigned best_length;
      longint unsigned best_start;
      gap_report_type  report;
      int              i;
      int              j;

      for (i = 0; i < table_count; i++) begin
         key_first = table_first[i];
         key_last  = table_last[i];
         j = i;
         while (j > 0 && sorted_first[j-1] > key_first) begin
            sorted_first[j] = sorted_first[j-1];
            sorted_last[j]  = sorted_last[j-1];
            j--;
         end
         sorted_first[j] = key_first;
         sorted_last[j]  = key_last;
      end

      align_mask  = (64'd1 << cfg_align_shift) - 64'd1;
      cursor      = cfg_low_sector;
      best_length = 0;
      best_start  = 0;
      for (i = 0; i <= table_count; i++) begin
         gap_end = (i < table_count) ? sorted_first[i] : cfg_high_sector + 64'd1;
         aligned = (cursor + align_mask) & ~align_mask;
         if (gap_end > aligned && gap_end - aligned > best_length) begin
            best_length = gap_end - aligned;
            best_start  = aligned;
         end
         // The cursor only ever moves forward, even past an extent whose
         // last sector lies below its first.
         if (i < table_count && sorted_last[i] + 64'd1 > cursor) begin
            cursor = sorted_last[i] + 64'd1;
         end
      end

      // An empty best gap is never reported, even with a zero minimum. A gap
      // of the whole 2^48 sector space saturates to the widest length.
      if (best_length == 0 || best_length < cfg_min_gap) begin
         report.found      = 1'b0;
         report.gap_start  = '0;
         report.gap_length = '0;
      end else begin
         report.found      = 1'b1;
         report.gap_start  = best_start[SECT_W-1:0];
         report.gap_length = (best_length > SECTOR_MASK) ? SECTOR_MASK[SECT_W-1:0]
                                                         : best_length[SECT_W-1:0];
      end
      return report;
   endfunction

   // Called for each accepted request transaction. Extents past the table
   // depth are dropped; a final request runs the search and empties the
   // table for the next one.
   function automatic void record_request(bit has_entry, longint unsigned first,
                                          longint unsigned last, bit is_final);
      if (has_entry && table_count < TABLE_DEPTH) begin
         table_first[table_count] = first & SECTOR_MASK;
         table_last[table_count]  = last & SECTOR_MASK;
         table_count++;
      end
      if (is_final) begin
         pending_gaps.push_back(predict_best_gap());
         table_count = 0;
      end
   endfunction

   function automatic void set_config(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_LOW_SECTOR:  cfg_low_sector  = data[SECT_W-1:0];
         REG_HIGH_SECTOR: cfg_high_sector = data[SECT_W-1:0];
         REG_ALIGN_SHIFT: cfg_align_shift = data[SHIFT_W-1:0];
         REG_MIN_GAP:     cfg_min_gap     = data[SECT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] register_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_LOW_SECTOR:  return CSR_DATA_W'(cfg_low_sector);
         REG_HIGH_SECTOR: return CSR_DATA_W'(cfg_high_sector);
         REG_ALIGN_SHIFT: return CSR_DATA_W'(cfg_align_shift);
         REG_MIN_GAP:     return CSR_DATA_W'(cfg_min_gap);
         default:         return '0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Register port.
   // ------------------------------------------------------------------

   // A setup phase, then an access phase that waits for pready. Registers are eight bytes apart
   // because some of them are wider than 32 bits.
   task automatic csr_access(bit is_write, logic [REG_IDX_W-1:0] idx,
                             logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = is_write;
      paddr   = {idx, 3'b000};
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_expect(logic [REG_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, idx, '0, readback);
      if (readback !== register_value(idx)) begin
         note_mismatch($sformatf("readback of register %0d", idx), readback, register_value(idx));
      end
   endtask

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] ignored;
      csr_access(1'b1, idx, data, ignored);
      set_config(idx, data);
      csr_expect(idx);
   endtask

   // Random bits above the register's width, now and then, to show that the
   // block keeps only the bits it owns.
   function automatic longint unsigned stray_bits_above(int width);
      if ($urandom_range(0, 3) != 0) begin
         return 0;
      end
      return ({$urandom, $urandom} >> width) << width;
   endfunction

   task automatic apply_settings(longint unsigned first, longint unsigned last, int shift,
                                 longint unsigned min_gap);
      csr_write(REG_LOW_SECTOR, stray_bits_above(SECT_W) | first);
      csr_write(REG_HIGH_SECTOR, stray_bits_above(SECT_W) | last);
      csr_write(REG_ALIGN_SHIFT, stray_bits_above(SHIFT_W) | longint'(shift & 31));
      csr_write(REG_MIN_GAP, stray_bits_above(SECT_W) | min_gap);
   endtask

   // ------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------

   // Sends one request transaction. The sender works in bursts: when a burst
   // runs out, valid drops for a random number of cycles and a new burst
   // length is drawn, sometimes a long one with no idling at all. A stalled
   // payload is held until the block takes it.
   task automatic send_request(bit has_entry, longint unsigned first, longint unsigned last,
                               bit is_final);
      int gap_cycles;
      if (burst_left == 0) begin
         gap_cycles = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap_cycles - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_has_entry    = has_entry;
      req_extent_first = first[SECT_W-1:0];
      req_extent_last  = last[SECT_W-1:0];
      req_final_item   = is_final;
      do @(posedge clock); while (req_stall);
      record_request(has_entry, first, last, is_final);
      total_items++;
      burst_left--;
   endtask

   // Holds the sender until every expected result has come back, then lets
   // the block settle. Registers are written only after this.
   task automatic pause_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_gaps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side.
   // ------------------------------------------------------------------

   // The receiver stalls on a pattern of its own: stretches of no stall,
   // coin-flip stall, mostly stalled, and a fixed periodic pattern.
   initial begin : receiver_pattern
      stall_mode_type mode;
      int             stretch;
      int             tick;
      rsp_stall = 1'b0;
      tick = 0;
      forever begin
         mode    = stall_mode_type'($urandom_range(0, 3));
         stretch = $urandom_range(40, 400);
         repeat (stretch) begin
            @(negedge clock);
            tick++;
            case (mode)
               STALL_NONE:  rsp_stall = 1'b0;
               STALL_COIN:  rsp_stall = 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
               default:     rsp_stall = ((tick % 13) < 9);
            endcase
         end
      end
   end

   // Each accepted result transaction is compared with the oldest report
   // still owed, field by field.
   always @(posedge clock) begin : check_results
      gap_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gaps.size() == 0) begin
            note_mismatch("result with nothing outstanding", 64'(rsp_gap_start), 64'd0);
         end else begin
            want = pending_gaps.pop_front();
            if (rsp_found !== want.found) begin
               note_mismatch("found", 64'(rsp_found), 64'(want.found));
            end
            if (rsp_gap_start !== want.gap_start) begin
               note_mismatch("gap_start", 64'(rsp_gap_start), 64'(want.gap_start));
            end
            if (rsp_gap_length !== want.gap_length) begin
               note_mismatch("gap_length", 64'(rsp_gap_length), 64'(want.gap_length));
            end
         end
      end
   end

   // Counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // The registers come out of reset with their documented values. With the
   // last usable sector at 0 the disk has no room past the rounded first
   // sector, so an empty table finds nothing.
   task automatic test_reset_values();
      csr_expect(REG_LOW_SECTOR);
      csr_expect(REG_HIGH_SECTOR);
      csr_expect(REG_ALIGN_SHIFT);
      csr_expect(REG_MIN_GAP);
      send_request(1'b0, 0, 0, 1'b1);
   endtask

   task automatic test_directed_cases();
      pause_for_results();
      // A disk of about one million sectors, 2048-sector alignment, and
      // every nonempty gap counting as found.
      apply_settings(34, 1_048_575, 11, 0);
      // An empty table: the whole usable range after rounding.
      send_request(1'b0, 0, 0, 1'b1);
      // A trigger-only request in the middle of a table changes nothing,
      // and a final request may carry an extent of its own.
      send_request(1'b1, 2048, 100_000, 1'b0);
      send_request(1'b0, SECTOR_MASK, SECTOR_MASK, 1'b0);
      send_request(1'b1, 500_000, 600_000, 1'b0);
      send_request(1'b1, 700_000, 700_000, 1'b1);
      // Two extents that start on the same sector.
      send_request(1'b1, 4096, 8191, 1'b0);
      send_request(1'b1, 4096, 300_000, 1'b0);
      send_request(1'b0, 0, 0, 1'b1);
      // An extent whose last sector lies below its first.
      send_request(1'b1, 200_000, 100, 1'b0);
      send_request(1'b1, 300_000, 400_000, 1'b1);
      // Extents that reach past the end of the usable range.
      send_request(1'b1, 1_500_000, 1_600_000, 1'b0);
      send_request(1'b1, 900_000, 2_000_000, 1'b1);
      // Two gaps of 8192 sectors after rounding; the earlier one must win.
      send_request(1'b1, 28_672, 1_048_575, 1'b0);
      send_request(1'b1, 10_240, 20_479, 1'b0);
      send_request(1'b0, 0, 0, 1'b1);
      // One extent over the whole sector space leaves no gap at all, and
      // nothing is found even though the minimum is zero.
      send_request(1'b1, 0, SECTOR_MASK, 1'b1);
      send_request(1'b1, SECTOR_MASK, 0, 1'b1);

      // The whole sector space is free: the gap of 2^48 sectors saturates.
      pause_for_results();
      apply_settings(0, SECTOR_MASK, 0, 0);
      send_request(1'b0, 0, 0, 1'b1);

      // The widest alignment and the largest minimum. The saturated gap
      // still meets the minimum; once a small extent pushes the cursor up
      // to 2^31 the rest falls short of it.
      pause_for_results();
      apply_settings(0, SECTOR_MASK, 31, SECTOR_MASK);
      send_request(1'b0, 0, 0, 1'b1);
      send_request(1'b1, 1, 5, 1'b1);
   endtask

   // More extents than the table holds. The two that do not fit would cover
   // the whole disk, so keeping either of them would hide every gap. A short
   // table afterward shows the count starting over.
   task automatic test_table_overflow();
      longint unsigned first;
      int              k;
      pause_for_results();
      apply_settings(0, 999_999, 4, 16);
      for (k = 0; k < TABLE_DEPTH + 2; k++) begin
         if (k < TABLE_DEPTH) begin
            first = rand_below(1_000_000);
            send_request(1'b1, first, first + $urandom_range(0, 3000), 1'b0);
         end else begin
            send_request(1'b1, 0, 999_999, 1'b0);
         end
      end
      send_request(1'b0, 0, 0, 1'b1);
      send_request(1'b1, 500_000, 600_000, 1'b0);
      send_request(1'b1, 100, 200, 1'b1);
   endtask

   // Draws one register setting for a random phase and returns the usable
   // window that its tables are placed in. Some phases take the extremes,
   // some the reset-style values, most a random disk of random scale with
   // an alignment that is usually small against the disk.
   task automatic pick_random_settings(output longint unsigned lo, output longint unsigned hi);
      longint unsigned first;
      longint unsigned last;
      longint unsigned min_gap;
      int              shift;
      int              bits;
      case ($urandom_range(0, 5))
         0: begin
            first   = 0;
            last    = SECTOR_MASK;
            shift   = $urandom_range(0, 1) ? 0 : 31;
            min_gap = $urandom_range(0, 1) ? 0 : SECTOR_MASK >> $urandom_range(0, 8);
         end
         1: begin
            bits    = $urandom_range(16, 30);
            first   = 34;
            last    = first + (64'd1 << bits) + rand_below(64'd1 << bits);
            shift   = 11;
            min_gap = 40960;
         end
         default: begin
            bits  = $urandom_range(6, 46);
            first = rand48() >> $urandom_range(1, 48);
            last  = first + (64'd1 << bits) - 1 + rand_below(64'd1 << bits);
            if (last > SECTOR_MASK) begin
               last = SECTOR_MASK;
            end
            if ($urandom_range(0, 7) == 0) begin
               shift = $urandom_range(0, 31);
            end else begin
               shift = $urandom_range(0, (bits - 4 < 24) ? bits - 4 : 24);
            end
            min_gap = $urandom_range(0, 3) == 0 ? 0
                    : rand_below((last - first) >> $urandom_range(2, 10));
         end
      endcase
      apply_settings(first, last, shift, min_gap);
      lo = first;
      hi = last;
   endtask

   // One table of extents placed at random inside the window, followed by a
   // final request. Most tables are short; a few are long. About one in
   // seven is broken up with extents of arbitrary 48-bit values and
   // requests without an entry.
   task automatic send_random_table(longint unsigned lo, longint unsigned hi);
      longint unsigned span;
      longint unsigned slice;
      longint unsigned first;
      longint unsigned last;
      int              pick;
      int              extents;
      int              k;
      bit              broken;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         extents = 0;
      end else if (pick < 90) begin
         extents = $urandom_range(1, 12);
      end else if (pick < 97) begin
         extents = $urandom_range(13, 40);
      end else begin
         extents = $urandom_range(41, 80);
      end
      broken = ($urandom_range(0, 6) == 0);
      span   = hi - lo + 1;
      slice  = span / (extents + 1);
      if (slice == 0) begin
         slice = 1;
      end
      for (k = 0; k < extents; k++) begin
         if (broken && $urandom_range(0, 2) == 0) begin
            send_request(1'($urandom_range(0, 1)), rand48(), rand48(), 1'b0);
         end else begin
            first = lo + rand_below(span);
            last  = first + rand_below(slice);
            send_request(1'b1, first & SECTOR_MASK, (last > SECTOR_MASK) ? SECTOR_MASK : last,
                         1'b0);
         end
         if ($urandom_range(0, 19) == 0) begin
            send_request(1'b0, rand48(), rand48(), 1'b0);
         end
      end
      if ($urandom_range(0, 1)) begin
         first = lo + rand_below(span);
         last  = first + rand_below(slice);
         send_request(1'b1, first & SECTOR_MASK, (last > SECTOR_MASK) ? SECTOR_MASK : last,
                      1'b1);
      end else begin
         send_request(1'b0, rand48(), rand48(), 1'b1);
      end
   endtask

   // Random phases, each with its own register setting. Every phase ends
   // with the sender waiting for all outstanding results.
   task automatic test_random_tables();
      longint unsigned lo;
      longint unsigned hi;
      int              tables;
      int              t;
      int              target;
      target = total_items + RANDOM_ITEMS;
      while (total_items < target) begin
         pause_for_results();
         pick_random_settings(lo, hi);
         tables = $urandom_range(6, 20);
         for (t = 0; t < tables; t++) begin
            send_random_table(lo, hi);
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_has_entry    = 1'b0;
      req_extent_first = '0;
      req_extent_last  = '0;
      req_final_item   = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_directed_cases();
      test_table_overflow();
      test_random_tables();

      // Wait for every owed result and a little longer for any stray one.
      pause_for_results();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
